/* rtl/assert_macros.svh */
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/jpd_pkg.sv */
package jpd_pkg;

  localparam int JOINT_COUNT_DEF = 12;
  localparam int VALUE_WIDTH_DEF = 16;

  localparam int IDX_W   = 4;
  localparam int FIELD_W = 16;
  localparam int TLIM_W  = 3 * FIELD_W;
  localparam int CIDX_W  = 3;
  localparam int DIFF_W  = FIELD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int FRAC_W  = 8;
  localparam int SUM_W   = PROD_W - FRAC_W + 2;

  localparam logic [CIDX_W-1:0] REG_SOFT_K  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_SOFT_D  = 3'd1;
  localparam logic [CIDX_W-1:0] REG_ABAD_UP = 3'd2;
  localparam logic [CIDX_W-1:0] REG_ABAD_LO = 3'd3;
  localparam logic [CIDX_W-1:0] REG_HIP_UP  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_HIP_LO  = 3'd5;
  localparam logic [CIDX_W-1:0] REG_TLIM    = 3'd6;

  typedef enum logic [1:0] {
    LAW_PD      = 2'd0,
    LAW_ABOVE   = 2'd1,
    LAW_BELOW   = 2'd2,
    LAW_INVALID = 2'd3
  } law_e;

  typedef enum logic [1:0] {
    KIND_ABAD = 2'd0,
    KIND_HIP  = 2'd1,
    KIND_KNEE = 2'd2
  } kind_e;

  typedef struct packed {
    logic [FIELD_W-1:0]        soft_k;
    logic [FIELD_W-1:0]        soft_d;
    logic signed [FIELD_W-1:0] abad_up;
    logic signed [FIELD_W-1:0] abad_lo;
    logic signed [FIELD_W-1:0] hip_up;
    logic signed [FIELD_W-1:0] hip_lo;
    logic [TLIM_W-1:0]         tlim;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]          joint;
    law_e                      law;
    logic                      sub;
    logic [FIELD_W-1:0]        gain_a;
    logic signed [DIFF_W-1:0]  diff_a;
    logic [FIELD_W-1:0]        gain_b;
    logic signed [DIFF_W-1:0]  diff_b;
    logic signed [FIELD_W-1:0] ff;
    logic [FIELD_W-1:0]        lim;
  } sel_t;

  typedef struct packed {
    logic [IDX_W-1:0]          joint;
    law_e                      law;
    logic                      sub;
    logic signed [PROD_W-1:0]  prod_a;
    logic signed [PROD_W-1:0]  prod_b;
    logic signed [FIELD_W-1:0] ff;
    logic [FIELD_W-1:0]        lim;
  } prod_t;

  typedef struct packed {
    logic [IDX_W-1:0]        joint;
    law_e                    law;
    logic signed [SUM_W-1:0] sum;
    logic [FIELD_W-1:0]      lim;
  } sum_t;

  // joint index mod 3
  function automatic kind_e joint_kind(logic [IDX_W-1:0] idx);
    kind_e k;
    case (idx)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: k = KIND_ABAD;
      4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       k = KIND_HIP;
      default:                              k = KIND_KNEE;
    endcase
    return k;
  endfunction

endpackage

/* rtl/jpd_cfg.sv */
module jpd_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [jpd_pkg::CIDX_W-1:0]  cfg_index_i,
  input  logic [jpd_pkg::TLIM_W-1:0]  cfg_data_i,
  output jpd_pkg::cfg_t               cfg_o
);
  import jpd_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SOFT_K:  cfg_d.soft_k  = cfg_data_i[FIELD_W-1:0];
        REG_SOFT_D:  cfg_d.soft_d  = cfg_data_i[FIELD_W-1:0];
        REG_ABAD_UP: cfg_d.abad_up = $signed(cfg_data_i[FIELD_W-1:0]);
        REG_ABAD_LO: cfg_d.abad_lo = $signed(cfg_data_i[FIELD_W-1:0]);
        REG_HIP_UP:  cfg_d.hip_up  = $signed(cfg_data_i[FIELD_W-1:0]);
        REG_HIP_LO:  cfg_d.hip_lo  = $signed(cfg_data_i[FIELD_W-1:0]);
        REG_TLIM:    cfg_d.tlim    = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/jpd_select.sv */
module jpd_select #(
  parameter int JOINT_COUNT = jpd_pkg::JOINT_COUNT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  jpd_pkg::cfg_t                      cfg_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [jpd_pkg::IDX_W-1:0]          joint_index_i,
  input  logic                               command_valid_i,
  input  logic signed [jpd_pkg::FIELD_W-1:0] position_i,
  input  logic signed [jpd_pkg::FIELD_W-1:0] velocity_i,
  input  logic signed [jpd_pkg::FIELD_W-1:0] target_position_i,
  input  logic signed [jpd_pkg::FIELD_W-1:0] target_velocity_i,
  input  logic [jpd_pkg::FIELD_W-1:0]        stiffness_gain_i,
  input  logic [jpd_pkg::FIELD_W-1:0]        damping_gain_i,
  input  logic signed [jpd_pkg::FIELD_W-1:0] feedforward_torque_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output jpd_pkg::sel_t                      data_o
);
  import jpd_pkg::*;

  localparam int JC_W  = $clog2(JOINT_COUNT + 1);
  localparam int CMP_W = (JC_W > IDX_W) ? JC_W : IDX_W;

  logic                      valid_q;
  sel_t                      data_q, data_d;
  kind_e                     kind;
  logic                      live;
  logic                      has_stop;
  logic                      soft_law;
  logic signed [FIELD_W-1:0] up_lim, lo_lim, stop;

  assign kind = joint_kind(joint_index_i);
  assign live = command_valid_i && (CMP_W'(joint_index_i) < CMP_W'(JOINT_COUNT));

  always_comb begin
    has_stop = 1'b0;
    up_lim   = cfg_i.abad_up;
    lo_lim   = cfg_i.abad_lo;
    case (kind)
      KIND_ABAD: begin
        has_stop = 1'b1;
      end
      KIND_HIP: begin
        has_stop = 1'b1;
        up_lim   = cfg_i.hip_up;
        lo_lim   = cfg_i.hip_lo;
      end
      default: ;
    endcase
  end

  always_comb begin
    data_d       = '0;
    data_d.joint = joint_index_i;
    if (!live) begin
      data_d.law = LAW_INVALID;
    end else if (has_stop && (position_i > up_lim)) begin
      data_d.law = LAW_ABOVE;
    end else if (has_stop && (position_i < lo_lim)) begin
      data_d.law = LAW_BELOW;
    end else begin
      data_d.law = LAW_PD;
    end
    soft_law = (data_d.law == LAW_ABOVE) || (data_d.law == LAW_BELOW);
    stop     = (data_d.law == LAW_ABOVE) ? up_lim : lo_lim;

    data_d.sub = soft_law;
    if (soft_law) begin
      data_d.gain_a = cfg_i.soft_k;
      data_d.diff_a = DIFF_W'(stop) - DIFF_W'(position_i);
      data_d.gain_b = cfg_i.soft_d;
      data_d.diff_b = DIFF_W'(velocity_i);
    end else begin
      data_d.gain_a = stiffness_gain_i;
      data_d.diff_a = DIFF_W'(target_position_i) - DIFF_W'(position_i);
      data_d.gain_b = damping_gain_i;
      data_d.diff_b = DIFF_W'(target_velocity_i) - DIFF_W'(velocity_i);
    end
    data_d.ff = feedforward_torque_i;

    case (kind)
      KIND_ABAD: data_d.lim = cfg_i.tlim[FIELD_W-1:0];
      KIND_HIP:  data_d.lim = cfg_i.tlim[2*FIELD_W-1:FIELD_W];
      default:   data_d.lim = cfg_i.tlim[3*FIELD_W-1:2*FIELD_W];
    endcase
  end

  assign in_ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/jpd_mac.sv */
module jpd_mac (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  jpd_pkg::sel_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output jpd_pkg::sum_t data_o
);
  import jpd_pkg::*;

  logic                    p_valid_q, s_valid_q;
  logic                    p_ready, s_ready;
  prod_t                   p_q, p_d;
  sum_t                    s_q, s_d;
  logic signed [PROD_W-1:0] sh_a, sh_b;
  logic signed [SUM_W-1:0]  term_a, term_b, term_ff;

  // stage 2: the two gain products
  always_comb begin
    p_d        = '0;
    p_d.joint  = data_i.joint;
    p_d.law    = data_i.law;
    p_d.sub    = data_i.sub;
    p_d.prod_a = $signed({1'b0, data_i.gain_a}) * data_i.diff_a;
    p_d.prod_b = $signed({1'b0, data_i.gain_b}) * data_i.diff_b;
    p_d.ff     = data_i.ff;
    p_d.lim    = data_i.lim;
  end

  // stage 3: floor shift and sum
  always_comb begin
    sh_a    = p_q.prod_a >>> FRAC_W;
    sh_b    = p_q.prod_b >>> FRAC_W;
    term_a  = $signed(sh_a[SUM_W-1:0]);
    term_b  = $signed(sh_b[SUM_W-1:0]);
    term_ff = $signed({{(SUM_W-FIELD_W){p_q.ff[FIELD_W-1]}}, p_q.ff});
    s_d       = '0;
    s_d.joint = p_q.joint;
    s_d.law   = p_q.law;
    s_d.lim   = p_q.lim;
    s_d.sum   = p_q.sub ? (term_a - term_b + term_ff) : (term_a + term_b + term_ff);
  end

  assign s_ready = !s_valid_q || ready_i;
  assign p_ready = !p_valid_q || s_ready;
  assign ready_o = p_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else begin
      if (p_ready) begin
        p_valid_q <= valid_i;
      end
      if (s_ready) begin
        s_valid_q <= p_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && p_ready) begin
      p_q <= p_d;
    end
    if (p_valid_q && s_ready) begin
      s_q <= s_d;
    end
  end

  assign valid_o = s_valid_q;
  assign data_o  = s_q;

endmodule

/* rtl/jpd_clamp.sv */
module jpd_clamp #(
  parameter int VALUE_WIDTH = jpd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  jpd_pkg::sum_t                 data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [jpd_pkg::IDX_W-1:0]     joint_number_o,
  output logic signed [VALUE_WIDTH-1:0] torque_o,
  output logic [1:0]                    law_used_o,
  output logic                          was_clamped_o
);
  import jpd_pkg::*;

  localparam int EXT_W = ((VALUE_WIDTH > SUM_W) ? VALUE_WIDTH : SUM_W) + 1;

  logic                          valid_q;
  logic [IDX_W-1:0]              joint_q;
  logic signed [VALUE_WIDTH-1:0] torque_q, torque_d;
  law_e                          law_q;
  logic                          clamped_q, clamped_d;
  logic signed [EXT_W-1:0]       t, lim_pos, lim_neg, vmax, vmin;

  assign vmax    = $signed(EXT_W'({1'b0, {(VALUE_WIDTH-1){1'b1}}}));
  assign vmin    = ~vmax;
  assign lim_pos = $signed(EXT_W'(data_i.lim));
  assign lim_neg = -lim_pos;

  always_comb begin
    t         = EXT_W'(data_i.sum);
    clamped_d = 1'b0;
    if (t > lim_pos) begin
      t         = lim_pos;
      clamped_d = 1'b1;
    end
    if (t < lim_neg) begin
      t         = lim_neg;
      clamped_d = 1'b1;
    end
    if (t > vmax) begin
      t         = vmax;
      clamped_d = 1'b1;
    end
    if (t < vmin) begin
      t         = vmin;
      clamped_d = 1'b1;
    end
    torque_d = $signed(t[VALUE_WIDTH-1:0]);
    if (data_i.law == LAW_INVALID) begin
      torque_d  = '0;
      clamped_d = 1'b0;
    end
  end

  assign ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      joint_q   <= data_i.joint;
      torque_q  <= torque_d;
      law_q     <= data_i.law;
      clamped_q <= clamped_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign joint_number_o = joint_q;
  assign torque_o       = torque_q;
  assign law_used_o     = law_q;
  assign was_clamped_o  = clamped_q;

endmodule

/* rtl/joint_pd_torque_with_soft_stop_unit.sv */
// PD joint torque controller with soft position stops. One joint sample is
// taken per clock and one torque result leaves per clock while the output
// is not stalled; each beat passes through four registered stages (select
// and limit compare, gain multiply, shift and sum, torque clamp), all four
// sharing one ready chain so that an output stall holds every beat in place.
// Config registers are written over the cfg channel (always ready, one
// register per beat) and must only change while no beat is in flight.
module joint_pd_torque_with_soft_stop_unit #(
  parameter int JOINT_COUNT = jpd_pkg::JOINT_COUNT_DEF,
  parameter int VALUE_WIDTH = jpd_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [jpd_pkg::CIDX_W-1:0]         cfg_index_i,
  input  logic [jpd_pkg::TLIM_W-1:0]         cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [jpd_pkg::IDX_W-1:0]          joint_index_i,
  input  logic                               command_valid_i,
  input  logic signed [jpd_pkg::FIELD_W-1:0] position_i,
  input  logic signed [jpd_pkg::FIELD_W-1:0] velocity_i,
  input  logic signed [jpd_pkg::FIELD_W-1:0] target_position_i,
  input  logic signed [jpd_pkg::FIELD_W-1:0] target_velocity_i,
  input  logic [jpd_pkg::FIELD_W-1:0]        stiffness_gain_i,
  input  logic [jpd_pkg::FIELD_W-1:0]        damping_gain_i,
  input  logic signed [jpd_pkg::FIELD_W-1:0] feedforward_torque_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [jpd_pkg::IDX_W-1:0]          joint_number_o,
  output logic signed [VALUE_WIDTH-1:0]      torque_o,
  output logic [1:0]                         law_used_o,
  output logic                               was_clamped_o
);
  import jpd_pkg::*;

  cfg_t cfg;
  sel_t sel_data;
  sum_t sum_data;
  logic sel_valid, sel_ready;
  logic sum_valid, sum_ready;

  jpd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  jpd_select #(
    .JOINT_COUNT (JOINT_COUNT)
  ) u_select (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .joint_index_i        (joint_index_i),
    .command_valid_i      (command_valid_i),
    .position_i           (position_i),
    .velocity_i           (velocity_i),
    .target_position_i    (target_position_i),
    .target_velocity_i    (target_velocity_i),
    .stiffness_gain_i     (stiffness_gain_i),
    .damping_gain_i       (damping_gain_i),
    .feedforward_torque_i (feedforward_torque_i),
    .valid_o              (sel_valid),
    .ready_i              (sel_ready),
    .data_o               (sel_data)
  );

  jpd_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sel_valid),
    .ready_o (sel_ready),
    .data_i  (sel_data),
    .valid_o (sum_valid),
    .ready_i (sum_ready),
    .data_o  (sum_data)
  );

  jpd_clamp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_clamp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (sum_valid),
    .ready_o        (sum_ready),
    .data_i         (sum_data),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .joint_number_o (joint_number_o),
    .torque_o       (torque_o),
    .law_used_o     (law_used_o),
    .was_clamped_o  (was_clamped_o)
  );

endmodule

/* rtl/jpd_checker.sv */
`include "assert_macros.svh"

module jpd_checker #(
  parameter int JOINT_COUNT = jpd_pkg::JOINT_COUNT_DEF,
  parameter int VALUE_WIDTH = jpd_pkg::VALUE_WIDTH_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [jpd_pkg::IDX_W-1:0]     joint_number_o,
  input logic signed [VALUE_WIDTH-1:0] torque_o,
  input logic [1:0]                    law_used_o,
  input logic                          was_clamped_o
);
  import jpd_pkg::*;

  localparam int JC_W  = $clog2(JOINT_COUNT + 1);
  localparam int CMP_W = (JC_W > IDX_W) ? JC_W : IDX_W;

  // input side only backs up when the result beat is held
  `ASSERT_IMPL(a_stall_source, clk_i, rst_ni, !in_ready_o, out_valid_o && !out_ready_i)
  // held result beat stays put
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(torque_o) && $stable(law_used_o) && $stable(was_clamped_o))
  // invalid beats carry no torque
  `ASSERT_IMPL(a_invalid_zero, clk_i, rst_ni, out_valid_o && (law_used_o == LAW_INVALID), (torque_o == '0) && !was_clamped_o)
  // out-of-range joints never run a control law
  `ASSERT_IMPL(a_range, clk_i, rst_ni, out_valid_o && (CMP_W'(joint_number_o) >= CMP_W'(JOINT_COUNT)), law_used_o == LAW_INVALID)

endmodule

bind joint_pd_torque_with_soft_stop_unit jpd_checker #(
  .JOINT_COUNT (JOINT_COUNT),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_jpd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .joint_number_o (joint_number_o),
  .torque_o       (torque_o),
  .law_used_o     (law_used_o),
  .was_clamped_o  (was_clamped_o)
);
